>>> hdl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 RGBA box blur
// Frame limits, field widths, controller states, controller/datapath command
// and status words, and the reciprocal lookup for the neighbor-count divide.
// ----------------------------------------------------------------------------
package bblur_pkg;

  // Frame limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Fixed field widths.
  localparam int FW_W   = 11;  // frame_width register
  localparam int FH_W   = 13;  // frame_height register
  localparam int CFG_DW = 13;  // widest register
  localparam int CFG_AW = 1;   // register index
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 4 * CHAN_W;
  localparam int SUM_W  = CHAN_W + 4;  // nine channel values

  // Register reset values.
  localparam int FW_RESET = 1024;
  localparam int FH_RESET = 1024;

  // Derived widths.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int AREA_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // Reciprocal multiply for the divide by the neighbor count.
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int CNT_W    = 4;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Input item kinds (tuser).
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_DIV
  } state_e;

  typedef struct packed {
    logic             load;      // latch input word, start line store read
    logic             zero_pix;  // flush word: store zeros
    logic [COL_W-1:0] addr;      // line store column
    logic             shift;     // advance window, write line stores
    logic             sum;       // register masked window sums
    logic             out_load;  // load the output register
    logic             left_en;
    logic             right_en;
    logic             top_en;
    logic             bot_en;
    logic             frame_end;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or drained this cycle
  } dp_stat_t;

  // floor(s / count) == (s * recip(count)) >> RECIP_SH for s <= 9 * 255.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    begin
      unique case (count)
        4'd2:    m = RECIP_W'(32768);
        4'd3:    m = RECIP_W'(21846);
        4'd4:    m = RECIP_W'(16384);
        4'd6:    m = RECIP_W'(10923);
        4'd9:    m = RECIP_W'(7282);
        default: m = RECIP_W'(65536);
      endcase
      return m;
    end
  endfunction

endpackage

>>> hdl/bblur_ctrl.sv
// ----------------------------------------------------------------------------
// bblur_ctrl: sequencer of the 3x3 RGBA box blur
// Holds the frame registers, scan position and output count, decides per
// word whether it is taken, emits a result and closes the frame.
// ----------------------------------------------------------------------------
module bblur_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bblur_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [bblur_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                         s_valid_i,
  input  logic                         s_kind_i,
  output logic                         s_ready_o,
  output bblur_pkg::dp_cmd_t           dp_cmd_o,
  input  bblur_pkg::dp_stat_t          dp_stat_i
);
  import bblur_pkg::*;

  state_e              state_q, state_d;
  logic [FW_W-1:0]     fw_q;
  logic [FH_W-1:0]     fh_q;
  logic [AREA_W-1:0]   area;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [AREA_W-1:0]   emit_cnt_q;
  logic                emit_q, last_q, left_q, right_q, top_q, bot_q;

  logic [W_W-1:0]      w_eff;
  logic [H_W-1:0]      h_eff;
  logic                draining, take, px_zero, emit_now, last_now, wrap;
  logic [COL_W:0]      col_inc;
  logic [AREA_W:0]     cnt_inc;

  // Clamp register values into the supported range.
  always_comb begin
    if (fw_q == '0) begin
      w_eff = W_W'(1);
    end else if (int'(fw_q) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = H_W'(1);
    end else if (int'(fh_q) > MAX_HEIGHT) begin
      h_eff = H_W'(MAX_HEIGHT);
    end else begin
      h_eff = H_W'(fh_q);
    end
  end

  assign area     = AREA_W'(w_eff) * AREA_W'(h_eff);
  assign draining = row_q >= h_eff;
  assign take     = (state_q == S_IDLE) && s_valid_i && (draining || s_kind_i == CMD_PIXEL);
  assign px_zero  = col_q == '0;
  assign emit_now = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && !px_zero);
  assign cnt_inc  = (AREA_W + 1)'(emit_cnt_q) + (AREA_W + 1)'(1);
  assign last_now = emit_now && (cnt_inc >= (AREA_W + 1)'(area));
  assign col_inc  = (COL_W + 1)'(col_q) + (COL_W + 1)'(1);
  assign wrap     = col_inc >= (COL_W + 1)'(w_eff);

  // Configuration, scan position and per-word flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FW_W'(FW_RESET);
      fh_q       <= FH_W'(FH_RESET);
      col_q      <= '0;
      row_q      <= '0;
      emit_cnt_q <= '0;
      emit_q     <= 1'b0;
      last_q     <= 1'b0;
      left_q     <= 1'b0;
      right_q    <= 1'b0;
      top_q      <= 1'b0;
      bot_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FRAME_WIDTH:  fw_q <= cfg_wdata_i[FW_W-1:0];
          REG_FRAME_HEIGHT: fh_q <= cfg_wdata_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        emit_q  <= emit_now;
        last_q  <= last_now;
        left_q  <= px_zero ? (w_eff > W_W'(1)) : (col_q > COL_W'(1));
        right_q <= !px_zero && ((COL_W + 1)'(col_q) < (COL_W + 1)'(w_eff));
        top_q   <= px_zero ? (row_q > ROW_W'(2)) : (row_q > ROW_W'(1));
        bot_q   <= px_zero ? (row_q <= ROW_W'(h_eff)) : (row_q < ROW_W'(h_eff));
        if (last_now) begin
          col_q      <= '0;
          row_q      <= '0;
          emit_cnt_q <= '0;
        end else begin
          if (wrap) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            col_q <= col_inc[COL_W-1:0];
          end
          if (emit_now) begin
            emit_cnt_q <= cnt_inc[AREA_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take) state_d = S_SHIFT;
      S_SHIFT: state_d = emit_q ? S_SUM : S_IDLE;
      S_SUM:   state_d = S_DIV;
      S_DIV:   if (dp_stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_ready_o          = state_q == S_IDLE;
    dp_cmd_o.load      = take;
    dp_cmd_o.zero_pix  = draining;
    dp_cmd_o.addr      = col_q;
    dp_cmd_o.shift     = state_q == S_SHIFT;
    dp_cmd_o.sum       = state_q == S_SUM;
    dp_cmd_o.out_load  = (state_q == S_DIV) && dp_stat_i.out_free;
    dp_cmd_o.left_en   = left_q;
    dp_cmd_o.right_en  = right_q;
    dp_cmd_o.top_en    = top_q;
    dp_cmd_o.bot_en    = bot_q;
    dp_cmd_o.frame_end = last_q;
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_now) |=> (col_q == '0 && row_q == '0 && emit_cnt_q == '0))
    else $error("frame end did not clear the scan position");

  a_sum_needs_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> emit_q)
    else $error("window sum started for a word without a result");

  a_div_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !dp_stat_i.out_free) |=> (state_q == S_DIV))
    else $error("result dropped while the output register was full");

endmodule

>>> hdl/bblur_dp.sv
// ----------------------------------------------------------------------------
// bblur_dp: datapath of the 3x3 RGBA box blur
// Line stores, 3x3 window, masked channel sums, reciprocal divide and the
// output register.
// ----------------------------------------------------------------------------
module bblur_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bblur_pkg::dp_cmd_t          dp_cmd_i,
  output bblur_pkg::dp_stat_t         dp_stat_o,
  input  logic [bblur_pkg::PIX_W-1:0] pix_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [bblur_pkg::PIX_W-1:0] m_data_o,
  output logic                        m_last_o
);
  import bblur_pkg::*;

  logic [PIX_W-1:0]   upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   up_rd_q, mid_rd_q, pix_q;
  logic [COL_W-1:0]   addr_q;
  logic [PIX_W-1:0]   win_q [3][3];  // [column: oldest..newest][row: top..bottom]
  logic [SUM_W-1:0]   sum_d [3];
  logic [SUM_W-1:0]   sum_q [3];
  logic [RECIP_W-1:0] recip_d, recip_q;
  logic [SUM_W+RECIP_W-1:0] prod [3];
  logic [PIX_W-1:0]   out_q;
  logic               out_valid_q, out_last_q;
  logic [2:0]         col_en, row_en;
  logic [1:0]         ncols, nrows;

  // Line stores: read on accept, write back on shift.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      up_rd_q  <= upper_mem[dp_cmd_i.addr];
      mid_rd_q <= middle_mem[dp_cmd_i.addr];
    end
    if (dp_cmd_i.shift) begin
      upper_mem[addr_q]  <= mid_rd_q;
      middle_mem[addr_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      addr_q <= dp_cmd_i.addr;
      pix_q  <= dp_cmd_i.zero_pix ? '0 : pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (dp_cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[0][r] <= win_q[1][r];
        win_q[1][r] <= win_q[2][r];
      end
      win_q[2][0] <= up_rd_q;
      win_q[2][1] <= mid_rd_q;
      win_q[2][2] <= pix_q;
    end
  end

  // Centre sits in column 1, row 1; mask the out-of-frame neighbors.
  assign col_en = {dp_cmd_i.right_en, 1'b1, dp_cmd_i.left_en};
  assign row_en = {dp_cmd_i.bot_en, 1'b1, dp_cmd_i.top_en};
  assign ncols  = 2'd1 + 2'(dp_cmd_i.left_en) + 2'(dp_cmd_i.right_en);
  assign nrows  = 2'd1 + 2'(dp_cmd_i.top_en) + 2'(dp_cmd_i.bot_en);
  assign recip_d = recip(CNT_W'(ncols) * CNT_W'(nrows));

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (col_en[c] && row_en[r]) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(win_q[c][r][CHAN_W*ch +: CHAN_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.sum) begin
      sum_q   <= sum_d;
      recip_q <= recip_d;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = (SUM_W + RECIP_W)'(sum_q[ch]) * (SUM_W + RECIP_W)'(recip_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.out_load) begin
      out_q <= {win_q[1][1][PIX_W-1 -: CHAN_W],
                prod[2][RECIP_SH +: CHAN_W],
                prod[1][RECIP_SH +: CHAN_W],
                prod[0][RECIP_SH +: CHAN_W]};
      out_last_q <= dp_cmd_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign dp_stat_o.out_free = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;
  assign m_last_o  = out_last_q;

endmodule

>>> hdl/box_blur_3x3_rgba_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba_core: streaming 3x3 box blur over RGBA pixels
// Raster-order pixels in, blurred pixels out one row plus one pixel later.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata {A,B,G,R}, tuser kind
//   m_axis    out        m_axis_tvalid/tready      tdata {A,B,G,R}, tlast
//   cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Steps: a word that yields a result passes accept with line store read,
//   window shift with line store write, masked sum and reciprocal divide
//   into the output register; a word with no result ends after the shift; an
//   ignored flush word is only accepted. The sequencer steps one word at a time.
// Reset: rst_ni clears the scan position, output count, window and output
//   valid; frame registers return to 1024 x 1024. Line stores need no clear.
// Stalls: the output register holds a result until taken; the next word is
//   accepted meanwhile and waits only at the divide step.
//
// R, G and B are the truncated mean over in-frame neighbors (divisor 9, 6, 4
// or fewer), applied as a multiply by a reciprocal. Alpha of the centre
// passes through. After the last pixel, feed flush words (tuser = 1) until
// the result with tlast arrives; a flush word inside the frame is dropped,
// and a pixel word after the last pixel counts as a flush word.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgba_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [bblur_pkg::CFG_AW-1:0] cfg_idx_i,     // 0 frame_width, 1 frame_height
  input  logic [bblur_pkg::CFG_DW-1:0] cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bblur_pkg::PIX_W-1:0]  s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
  input  logic                         s_axis_tuser,  // cmd: 0 pixel, 1 flush
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bblur_pkg::PIX_W-1:0]  m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                         m_axis_tlast   // frame_end
);
  import bblur_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer: frame registers, scan position, word decisions.
  bblur_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_kind_i    (s_axis_tuser),
    .s_ready_o   (s_axis_tready),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  // Line stores, window, arithmetic and output register.
  bblur_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dp_cmd_i  (dp_cmd),
    .dp_stat_o (dp_stat),
    .pix_i     (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

>>> test/box_blur_3x3_rgba_core_tb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba_core_tb: self-checking bench for the 3x3 RGBA box blur
// Drives frames of random pixels, with flush words and stray words mixed in,
// through the stream input under random gaps and output stalls. A scoreboard
// predicts every blurred word and compares each output word field by field.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgba_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bblur_pkg::*;

  // One expected or observed output word, split into its fields.
  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              frame_end;
  } blur_px_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own line stores, window and scan position, and
  // queues the blurred words that each accepted input word produces.
  // --------------------------------------------------------------------------
  class blur_scoreboard;
    bit [FW_W-1:0]  width_reg;
    bit [FH_W-1:0]  height_reg;
    bit [PIX_W-1:0] upper_line [MAX_WIDTH];
    bit [PIX_W-1:0] middle_line [MAX_WIDTH];
    bit [PIX_W-1:0] win [3][3];  // [column: oldest..newest][row: top..bottom]
    int unsigned    col_pos;
    int unsigned    row_pos;
    int unsigned    sent_cnt;
    int unsigned    taken;
    int unsigned    errors;
    blur_px_t       blurred_q [$];

    function new();
      width_reg  = FW_W'(FW_RESET);
      height_reg = FH_W'(FH_RESET);
      col_pos    = 0;
      row_pos    = 0;
      sent_cnt   = 0;
      taken      = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, int unsigned val);
      if (idx == REG_FRAME_WIDTH) width_reg = FW_W'(val);
      else height_reg = FH_W'(val);
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit draining();
      return row_pos >= eff_h();
    endfunction

    // Truncated mean around window column c; l and r are -1 when the
    // neighbor column lies outside the frame.
    function blur_px_t mean_at(int c, int l, int r, bit top_ok, bit bot_ok);
      int unsigned sum [3];
      int unsigned cnt;
      int          cols [3];
      blur_px_t    px;
      sum  = '{0, 0, 0};
      cnt  = 0;
      cols = '{l, c, r};
      foreach (cols[ci]) begin
        if (cols[ci] < 0) continue;
        for (int row = 0; row < 3; row++) begin
          if ((row == 0 && !top_ok) || (row == 2 && !bot_ok)) continue;
          for (int ch = 0; ch < 3; ch++) sum[ch] += win[cols[ci]][row][8*ch +: 8];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      px.red       = CHAN_W'(sum[0] / cnt);
      px.green     = CHAN_W'(sum[1] / cnt);
      px.blue      = CHAN_W'(sum[2] / cnt);
      px.alpha     = win[c][1][31:24];
      px.frame_end = 1'b0;
      return px;
    endfunction

    function void note_input(logic kind, logic [PIX_W-1:0] word);
      int unsigned    w, h, px, py, cx, cy, idx;
      bit             drain_phase, emit, have;
      bit [PIX_W-1:0] pix, a, b;
      blur_px_t       res;
      w           = eff_w();
      h           = eff_h();
      px          = col_pos;
      py          = row_pos;
      drain_phase = py >= h;
      have        = 1'b0;
      if (!drain_phase && kind == CMD_DRAIN) return;
      taken++;
      pix  = drain_phase ? '0 : word;
      emit = (py >= 2) || (py == 1 && px >= 1);

      // Row start: the centre is the last pixel two rows up.
      if (emit && px == 0) begin
        cx   = w - 1;
        cy   = py - 2;
        res  = mean_at(2, (cx > 0) ? 1 : -1, -1, cy > 0, cy + 1 < h);
        have = 1'b1;
      end

      idx = (px < MAX_WIDTH) ? px : 0;
      a   = upper_line[idx];
      b   = middle_line[idx];
      for (int k = 0; k < 3; k++) begin
        win[0][k] = win[1][k];
        win[1][k] = win[2][k];
      end
      win[2][0]        = a;
      win[2][1]        = b;
      win[2][2]        = pix;
      upper_line[idx]  = b;
      middle_line[idx] = pix;

      if (emit && px != 0) begin
        cx   = px - 1;
        cy   = py - 1;
        res  = mean_at(1, (cx > 0) ? 0 : -1, (cx + 1 < w) ? 2 : -1, cy > 0, cy + 1 < h);
        have = 1'b1;
      end

      if (px + 1 >= w) begin
        col_pos = 0;
        row_pos = py + 1;
      end else begin
        col_pos = px + 1;
      end

      if (have) begin
        if (sent_cnt + 1 >= w * h) begin
          res.frame_end = 1'b1;
          col_pos       = 0;
          row_pos       = 0;
          sent_cnt      = 0;
        end else begin
          sent_cnt++;
        end
        blurred_q.push_back(res);
      end
    endfunction

    function void cmp_field(string name, logic [CHAN_W-1:0] exp_v, logic [CHAN_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [PIX_W-1:0] data, logic last);
      blur_px_t e;
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %08h last %0b",
                 $time, data, last);
        errors++;
        return;
      end
      e = blurred_q.pop_front();
      cmp_field("out_red",   e.red,   data[7:0]);
      cmp_field("out_green", e.green, data[15:8]);
      cmp_field("out_blue",  e.blue,  data[23:16]);
      cmp_field("out_alpha", e.alpha, data[31:24]);
      cmp_field("frame_end", CHAN_W'(e.frame_end), CHAN_W'(last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CFG_AW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata;   // in_red, in_green, in_blue, in_alpha
  logic              s_axis_tuser;   // cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [PIX_W-1:0]  m_axis_tdata;   // out_red, out_green, out_blue, out_alpha
  logic              m_axis_tlast;   // frame_end

  blur_scoreboard sb = new();
  bit             tx_burst;  // sender offers back to back when set

  always #4 clk_i = ~clk_i;

  box_blur_3x3_rgba_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one word after a random gap; return at the edge that accepts it.
  // Valid is only dropped when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input logic kind, input logic [PIX_W-1:0] word);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, word);
  endtask

  // Hold until every predicted word has come out, then let the pipeline settle
  // in case a word that yields nothing is still in flight.
  task automatic wait_idle(input int settle);
    while (sb.blurred_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write width, then height, on consecutive edges; enable drops once, after both.
  task automatic write_frame_regs(input int unsigned wreg, input int unsigned hreg);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_wdata_i <= CFG_DW'(wreg);
    @(posedge clk_i);
    sb.set_reg(REG_FRAME_WIDTH, wreg);
    cfg_idx_i   <= REG_FRAME_HEIGHT;
    cfg_wdata_i <= CFG_DW'(hreg);
    @(posedge clk_i);
    sb.set_reg(REG_FRAME_HEIGHT, hreg);
    cfg_we_i    <= 1'b0;
  endtask

  // Flush the tail of the frame until the flagged word is predicted. In noisy
  // mode some flush slots carry pixel words, which the block must treat as flush.
  task automatic finish_frame(input bit noisy);
    while (sb.draining()) begin
      if (noisy && $urandom_range(0, 2) == 0) send_word(CMD_PIXEL, $urandom);
      else send_word(CMD_DRAIN, $urandom);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // One whole frame of random pixels. Noisy frames scatter flush words inside
  // the frame, which must be dropped.
  task automatic run_frame(input int unsigned wreg, input int unsigned hreg, input bit noisy);
    int unsigned    npix;
    logic [PIX_W-1:0] word;
    wait_idle(8);
    write_frame_regs(wreg, hreg);
    npix = sb.eff_w() * sb.eff_h();
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_word(CMD_DRAIN, $urandom);
      // Bias toward saturated words so the widest sums show up.
      case ($urandom_range(0, 7))
        0:       word = '1;
        1:       word = '0;
        default: word = $urandom;
      endcase
      send_word(CMD_PIXEL, word);
    end
    finish_frame(noisy);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, with bursts of no stalls and two long hold-offs
  // that let the block fill up and stall its input.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int nres;
    bit rx_burst;
    nres          = 0;
    rx_burst      = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (nres % 50 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (nres == 40 || nres == 700) stall = 500;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata, m_axis_tlast);
      nres++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_PIXEL;
    tx_burst      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 3x2 frame with extreme and alternating channel values.
    // Open with a flush word that has nothing to flush, drop one flush word
    // mid-frame, and follow the last pixel with a pixel word that acts as flush.
    write_frame_regs(3, 2);
    send_word(CMD_DRAIN, '0);
    send_word(CMD_PIXEL, 32'hFFFF_FFFF);
    send_word(CMD_PIXEL, 32'h0000_0000);
    send_word(CMD_PIXEL, 32'hAAAA_AAAA);
    send_word(CMD_DRAIN, '1);
    send_word(CMD_PIXEL, 32'h5555_5555);
    send_word(CMD_PIXEL, 32'h00FF_00FF);
    send_word(CMD_PIXEL, 32'hFF00_FF00);
    send_word(CMD_PIXEL, 32'h1234_5678);
    finish_frame(1'b0);

    // Directed: zero registers act as a one-pixel frame (divisor of one).
    wait_idle(8);
    write_frame_regs(0, 0);
    send_word(CMD_DRAIN, '1);
    send_word(CMD_PIXEL, 32'h80FF_01FE);
    finish_frame(1'b0);

    // Random: mostly small frames with noise, a few wider ones.
    while (sb.taken < 1250) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      run_frame(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12),
                $urandom_range(0, 8), 1'b1);
    end

    wait_idle(16);
    if (sb.errors == 0 && sb.blurred_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
